// ===== src/lru_rank_cache_directory_unit_assert.svh =====
// assertion macros for the lru rank cache directory
// used by lru_rank_cache_directory_unit; no other dependencies
`ifndef LRU_RANK_CACHE_DIRECTORY_UNIT_ASSERT_SVH
`define LRU_RANK_CACHE_DIRECTORY_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while rst_n is low
`define LRCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrcd assertion failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define LRCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrcd assertion failed");
`else
`define LRCD_ASSERT_NOW(label, ante, cons)
`define LRCD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/lrcd_pkg.sv =====
// shared types and constants for the lru rank cache directory
// no dependencies
package lrcd_pkg;

    localparam int KEY_BITS      = 32;   // width of the key_tag port
    localparam int RANK_BITS     = 5;
    localparam int WAY_OUT_BITS  = 4;    // width of the way_index port
    localparam logic [RANK_BITS-1:0] RANK_MAX = 5'd31;
    localparam logic [RANK_BITS-1:0] RANK_MRU = 5'd1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

// ===== src/lru_rank_cache_directory_unit.sv =====
// lru rank cache directory: fully associative tag directory, rank based lru
// depends on lrcd_pkg and lru_rank_cache_directory_unit_assert.svh
//
// A fully associative directory of WAYS tagged entries. Each request item carries a
// key tag; the response item tells whether it hit, which way hit or was filled, and
// whether a fill evicted the least recently used entry (highest rank, lowest way on a
// tie). Tags and ranks live in one synchronous memory with a single read and a single
// write port and a registered read; valid bits are flip-flops cleared by reset,
// so no clearing pass is needed. Every item walks the memory twice: a scan pass reads
// each way to find the match, the lowest free way and the highest rank, then an update
// pass reads each way again and writes back the bumped rank (and the new tag for a
// fill). A done state then loads the response register and returns to idle, where the
// next request can be taken; the time per item is set by the single memory read port
// stepping through all ways twice. Requests are taken one at a time; a finished
// response waits in its own register, so the next request may be accepted while
// it is still stalled.
module lru_rank_cache_directory_unit #(
    parameter int WAYS     = 16,
    parameter int TAG_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [lrcd_pkg::KEY_BITS-1:0]       key_tag,
    input  logic                                fill_on_miss,
    // response channel
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic                                hit,
    output logic [lrcd_pkg::WAY_OUT_BITS-1:0]   way_index,
    output logic                                allocated,
    output logic                                evicted
);

    `include "lru_rank_cache_directory_unit_assert.svh"

    localparam int RB     = lrcd_pkg::RANK_BITS;
    localparam int WAY_W  = $clog2(WAYS);
    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam int WORD_W = TAG_BITS + RB;

    // tag and rank memory, one word per way: {tag, rank}
    logic [WORD_W-1:0] mem [WAYS];

    logic [WORD_W-1:0] rd_data_reg;
    logic [WAY_W-1:0]  rd_way_reg;
    logic              rd_en_reg;
    logic              rd_en;
    logic [WAY_W-1:0]  rd_addr;

    logic              mem_we;
    logic [WAY_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    lrcd_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WAYS-1:0]   valid_reg, valid_next;

    // per item context
    logic [TAG_BITS-1:0] key_reg, key_next;
    logic                fill_reg, fill_next;

    // scan results
    logic                match_found_reg, match_found_next;
    logic [WAY_W-1:0]    match_way_reg, match_way_next;
    logic [RB-1:0]       match_rank_reg, match_rank_next;
    logic                free_found_reg, free_found_next;
    logic [WAY_W-1:0]    free_way_reg, free_way_next;
    logic [RB-1:0]       best_reg, best_next;
    logic [WAY_W-1:0]    victim_reg, victim_next;

    // response register
    logic                rsp_valid_reg, rsp_valid_next;
    logic                rsp_load;
    logic                hit_reg;
    logic [lrcd_pkg::WAY_OUT_BITS-1:0] way_reg;
    logic                allocated_reg;
    logic                evicted_reg;

    logic [TAG_BITS-1:0] rd_tag;
    logic [RB-1:0]       rd_rank;
    logic [RB-1:0]       rd_rank_inc;
    logic                last_rd;
    logic [WAY_W-1:0]    target_way;
    logic                do_update;
    logic                bump;

    assign rd_tag      = rd_data_reg[WORD_W-1:RB];
    assign rd_rank     = rd_data_reg[RB-1:0];
    assign rd_rank_inc = (rd_rank == lrcd_pkg::RANK_MAX) ? rd_rank : rd_rank + 1'b1;

    // one read per cycle while a pass is walking the ways
    assign rd_en   = ((state_reg == lrcd_pkg::ST_SCAN) || (state_reg == lrcd_pkg::ST_UPDATE))
                     && (cnt_reg < CNT_W'(WAYS));
    assign rd_addr = cnt_reg[WAY_W-1:0];
    assign last_rd = rd_en_reg && (rd_way_reg == WAY_W'(WAYS - 1));

    // hit keeps its way, fill prefers the lowest free way, else the oldest
    assign target_way = match_found_reg ? match_way_reg :
                        (free_found_reg ? free_way_reg : victim_reg);
    // a hit on the most recent entry or a plain lookup miss leaves state alone
    assign do_update  = match_found_reg ? (match_rank_reg != lrcd_pkg::RANK_MRU) : fill_reg;
    // on a hit only younger entries age, on a fill every other valid entry ages
    assign bump       = match_found_reg ? (rd_rank < match_rank_reg) : 1'b1;

    assign req_stall = (state_reg != lrcd_pkg::ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        valid_next       = valid_reg;
        key_next         = key_reg;
        fill_next        = fill_reg;
        match_found_next = match_found_reg;
        match_way_next   = match_way_reg;
        match_rank_next  = match_rank_reg;
        free_found_next  = free_found_reg;
        free_way_next    = free_way_reg;
        best_next        = best_reg;
        victim_next      = victim_reg;
        mem_we           = 1'b0;
        wr_addr          = rd_way_reg;
        wr_data          = {rd_tag, rd_rank_inc};
        rsp_load         = 1'b0;

        if (rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        case (state_reg)
            lrcd_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_next         = TAG_BITS'(key_tag);
                    fill_next        = fill_on_miss;
                    match_found_next = 1'b0;
                    match_way_next   = '0;
                    match_rank_next  = '0;
                    free_found_next  = 1'b0;
                    free_way_next    = '0;
                    best_next        = '0;
                    victim_next      = '0;
                    cnt_next         = '0;
                    state_next       = lrcd_pkg::ST_SCAN;
                end
            end
            lrcd_pkg::ST_SCAN:
            begin
                if (rd_en_reg)
                begin
                    if (valid_reg[rd_way_reg])
                    begin
                        if (!match_found_reg && (rd_tag == key_reg))
                        begin
                            match_found_next = 1'b1;
                            match_way_next   = rd_way_reg;
                            match_rank_next  = rd_rank;
                        end
                        if (rd_rank > best_reg)
                        begin
                            best_next   = rd_rank;
                            victim_next = rd_way_reg;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_way_next   = rd_way_reg;
                    end
                end
                if (last_rd)
                begin
                    cnt_next   = '0;
                    state_next = lrcd_pkg::ST_UPDATE;
                end
            end
            lrcd_pkg::ST_UPDATE:
            begin
                // write lags the read by one way, so the two never meet
                if (rd_en_reg && do_update)
                begin
                    if (rd_way_reg == target_way)
                    begin
                        mem_we                 = 1'b1;
                        wr_data                = {key_reg, lrcd_pkg::RANK_MRU};
                        valid_next[rd_way_reg] = 1'b1;
                    end
                    else if (valid_reg[rd_way_reg] && bump)
                    begin
                        mem_we = 1'b1;
                    end
                end
                if (last_rd)
                begin
                    state_next = lrcd_pkg::ST_DONE;
                end
            end
            lrcd_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = lrcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrcd_pkg::ST_IDLE;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_way_reg  <= rd_addr;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrcd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            rd_en_reg     <= 1'b0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_en_reg     <= rd_en;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // item context, scan results and response payload
    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        fill_reg        <= fill_next;
        match_found_reg <= match_found_next;
        match_way_reg   <= match_way_next;
        match_rank_reg  <= match_rank_next;
        free_found_reg  <= free_found_next;
        free_way_reg    <= free_way_next;
        best_reg        <= best_next;
        victim_reg      <= victim_next;
        if (rsp_load)
        begin
            hit_reg       <= match_found_reg;
            way_reg       <= (match_found_reg || fill_reg) ?
                             lrcd_pkg::WAY_OUT_BITS'(target_way) : '0;
            allocated_reg <= !match_found_reg && fill_reg;
            evicted_reg   <= !match_found_reg && fill_reg && !free_found_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign hit       = hit_reg;
    assign way_index = way_reg;
    assign allocated = allocated_reg;
    assign evicted   = evicted_reg;

    // an accepted item always starts a scan pass
    `LRCD_ASSERT_NEXT(a_accept_scan, req_valid && !req_stall, state_reg == lrcd_pkg::ST_SCAN)
    // memory is written only by the update pass
    `LRCD_ASSERT_NOW(a_write_in_update, mem_we, state_reg == lrcd_pkg::ST_UPDATE)
    // an eviction is always an allocation on a miss
    `LRCD_ASSERT_NOW(a_evict_alloc, rsp_valid_reg && evicted_reg, allocated_reg && !hit_reg)
    // the response register is loaded only when it is free or draining
    `LRCD_ASSERT_NOW(a_rsp_no_overwrite, rsp_load, !rsp_valid_reg || !rsp_stall)

endmodule
